// File: design/kks_pkg.sv
// Shared types and keysym codes for the keycode to keysym translator.
`default_nettype none

package kks_pkg;

  localparam int unsigned SymW = 16;

  // Keysym codes that the modifier logic recognizes.
  localparam logic [SymW-1:0] SymShiftL    = 16'hFFE1;
  localparam logic [SymW-1:0] SymShiftR    = 16'hFFE2;
  localparam logic [SymW-1:0] SymCtrlL     = 16'hFFE3;
  localparam logic [SymW-1:0] SymCtrlR     = 16'hFFE4;
  localparam logic [SymW-1:0] SymCapsLock  = 16'hFFE5;
  localparam logic [SymW-1:0] SymAltL      = 16'hFFE9;
  localparam logic [SymW-1:0] SymAltR      = 16'hFFEA;
  localparam logic [SymW-1:0] SymNumLock   = 16'hFF7F;
  localparam logic [SymW-1:0] SymBackSpace = 16'hFF08;
  localparam logic [SymW-1:0] SymKp0       = 16'hFFB0;
  localparam logic [SymW-1:0] SymKp9       = 16'hFFB9;
  localparam logic [SymW-1:0] SymKpDecimal = 16'hFFAE;
  localparam logic [SymW-1:0] SymLowerA    = 16'h0061;
  localparam logic [SymW-1:0] SymLowerZ    = 16'h007A;

  // Item kinds carried on the input tuser.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpEvent = 1'b1;

  // Event that has read its table entry and is ready for selection.
  typedef struct packed {
    logic            valid;
    logic            pressed;
    logic            in_range;
  } kks_event_t;

  // One translated key event.
  typedef struct packed {
    logic            quit_request;
    logic            used_shifted;
    logic            is_press;
    logic [SymW-1:0] key_sym;
  } kks_result_t;

endpackage

`default_nettype wire

// File: design/keycode_to_keysym_modifiers.sv
// Top level of the keycode to keysym translator with modifier tracking.
// Load transfers (tuser low) write the normal and shifted keysym of one keycode into a
// one-port-write, registered-read table and produce no output; keycodes at or beyond
// NUM_KEYS are dropped on load and read as zero keysyms on events. Event transfers
// (tuser high) read the table at the accepting edge. Once the output register is free they
// update the shift, control, alt, caps lock and num lock state and load the chosen keysym
// into the output register, from which the result is offered. The table read register and
// the output register let one transfer be accepted every cycle while the output is
// drained; an event right after a load sees that load's write. No clearing pass runs
// after reset: reading a keycode that was never loaded gives an arbitrary keysym.
`default_nettype none

module keycode_to_keysym_modifiers
  import kks_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [6:0] key_code, [7] pressed, [23:8] normal_sym, [39:24] shifted_sym
  input  wire logic [39:0] s_axis_tdata,
  // [0] op
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] key_sym, [16] is_press, [17] used_shifted, [18] quit_request, [23:19] zero
  output logic      [23:0] m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(NUM_KEYS);
  localparam logic [8:0]  NumKeysW = 9'(NUM_KEYS);

  logic             in_accept;
  logic             is_event;
  logic [8:0]       code_ext;
  logic             in_range;
  logic [AddrW-1:0] addr;

  kks_event_t        ev_q, ev_d;
  logic              out_free;
  logic              advance;
  logic [2*SymW-1:0] rd_syms;
  kks_result_t       result;
  kks_result_t       out_q;
  logic              out_valid_q;

  assign code_ext = {2'b00, s_axis_tdata[6:0]};
  assign in_range = code_ext < NumKeysW;
  assign addr     = code_ext[AddrW-1:0];
  assign is_event = (s_axis_tuser == OpEvent);

  // The event in the read stage moves on when the output register is empty or draining.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = ev_q.valid && out_free;
  assign s_axis_tready = !ev_q.valid || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  kks_table #(
    .Depth (NUM_KEYS),
    .AddrW (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (in_accept && !is_event && in_range),
    .waddr_i (addr),
    .wdata_i (s_axis_tdata[39:8]),
    .re_i    (in_accept && is_event),
    .raddr_i (addr),
    .rdata_o (rd_syms)
  );

  kks_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .event_i   (ev_q),
    .syms_i    (rd_syms),
    .result_o  (result)
  );

  always_comb begin
    ev_d = ev_q;
    if (in_accept) begin
      ev_d.valid    = is_event;
      ev_d.pressed  = s_axis_tdata[7];
      ev_d.in_range = in_range;
    end else if (advance) begin
      ev_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ev_q <= ev_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.quit_request, out_q.used_shifted, out_q.is_press,
                          out_q.key_sym};

endmodule

`default_nettype wire

// File: design/kks_table.sv
// Keysym table memory: one normal and one shifted keysym per keycode.
`default_nettype none

module kks_table
  import kks_pkg::*;
#(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrW-1:0]    waddr_i,
  input  wire logic [2*SymW-1:0]   wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrW-1:0]    raddr_i,
  output logic      [2*SymW-1:0]   rdata_o
);

  // Low half holds the normal keysym, high half the shifted one.
  logic [2*SymW-1:0] mem_q [Depth];
  logic [2*SymW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/kks_mod.sv
// Modifier state tracking and shifted keysym selection for key events.
`default_nettype none

module kks_mod
  import kks_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire kks_event_t        event_i,
  input  wire logic [2*SymW-1:0] syms_i,
  output kks_result_t            result_o
);

  logic       shift_q, shift_d;
  logic       ctrl_q, ctrl_d;
  logic       alt_q, alt_d;
  logic [1:0] caps_q, caps_d;
  logic [1:0] num_q, num_d;

  logic [SymW-1:0] nsym;
  logic [SymW-1:0] ssym;
  logic            kp_hit;
  logic            alpha_hit;
  logic            use_shift;
  logic [SymW-1:0] sel_sym;

  // Bit 0 toggles once per press; bit 1 blocks further toggles until release.
  function automatic logic [1:0] lock_next(input logic [1:0] st, input logic press);
    logic [1:0] nxt;
    nxt = st;
    if (press) begin
      if (!st[1]) begin
        nxt = {1'b1, ~st[0]};
      end
    end else begin
      nxt = {1'b0, st[0]};
    end
    return nxt;
  endfunction

  always_comb begin
    nsym = event_i.in_range ? syms_i[SymW-1:0] : '0;
    ssym = event_i.in_range ? syms_i[2*SymW-1:SymW] : '0;

    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    alt_d   = alt_q;
    caps_d  = caps_q;
    num_d   = num_q;
    case (nsym)
      SymShiftL, SymShiftR: shift_d = event_i.pressed;
      SymCtrlL, SymCtrlR:   ctrl_d  = event_i.pressed;
      SymAltL, SymAltR:     alt_d   = event_i.pressed;
      SymCapsLock:          caps_d  = lock_next(caps_q, event_i.pressed);
      SymNumLock:           num_d   = lock_next(num_q, event_i.pressed);
      default: ;
    endcase

    // Selection sees the modifier state after this event's own update.
    kp_hit    = num_d[0] && (((ssym >= SymKp0) && (ssym <= SymKp9)) ||
                             (ssym == SymKpDecimal));
    alpha_hit = caps_d[0] && (nsym >= SymLowerA) && (nsym <= SymLowerZ);
    use_shift = (kp_hit || alpha_hit) ^ shift_d;
    sel_sym   = use_shift ? ssym : nsym;

    result_o.key_sym      = sel_sym;
    result_o.is_press     = event_i.pressed;
    result_o.used_shifted = use_shift;
    result_o.quit_request = (sel_sym == SymBackSpace) && ctrl_d && alt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      ctrl_q  <= 1'b0;
      alt_q   <= 1'b0;
      caps_q  <= 2'b00;
      num_q   <= 2'b00;
    end else if (advance_i) begin
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      alt_q   <= alt_d;
      caps_q  <= caps_d;
      num_q   <= num_d;
    end
  end

endmodule

`default_nettype wire

// File: verif/keysym_translation_monitor.sv
// Watches both streams of the keycode translator, predicts each event result and compares.
`timescale 1ns / 1ps

module keysym_translation_monitor
  import kks_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [6:0] key_code, [7] pressed, [23:8] normal_sym, [39:24] shifted_sym
  input  logic [39:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] key_sym, [16] is_press, [17] used_shifted, [18] quit_request, [23:19] zero
  input  logic [23:0] m_axis_tdata,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  logic [SymW-1:0] normal_keysyms  [NUM_KEYS];
  logic [SymW-1:0] shifted_keysyms [NUM_KEYS];
  logic            shift_down;
  logic            control_down;
  logic            alt_down;
  // Bit 0 is the lock toggle, bit 1 holds off further toggles until release.
  logic [1:0]      caps_lock_state;
  logic [1:0]      num_lock_state;

  kks_result_t     expected_keysyms [$];
  int unsigned     mismatch_total;

  function automatic logic [1:0] next_lock_state(input logic [1:0] state, input logic pressed);
    if (!pressed) begin
      return {1'b0, state[0]};
    end
    if (state[1]) begin
      return state;
    end
    return {1'b1, ~state[0]};
  endfunction

  function automatic kks_result_t translate_key_event(input logic [6:0] code,
                                                     input logic       pressed);
    logic [SymW-1:0] nsym;
    logic [SymW-1:0] ssym;
    logic            keypad_hit;
    logic            letter_hit;
    logic            take_shifted;
    kks_result_t     res;
    nsym = '0;
    ssym = '0;
    if (code < NUM_KEYS) begin
      nsym = normal_keysyms[code];
      ssym = shifted_keysyms[code];
    end
    case (nsym)
      SymShiftL, SymShiftR: shift_down   = pressed;
      SymCtrlL, SymCtrlR:   control_down = pressed;
      SymAltL, SymAltR:     alt_down     = pressed;
      SymCapsLock:          caps_lock_state = next_lock_state(caps_lock_state, pressed);
      SymNumLock:           num_lock_state  = next_lock_state(num_lock_state, pressed);
      default: ;
    endcase
    keypad_hit = num_lock_state[0] &&
                 ((ssym >= SymKp0 && ssym <= SymKp9) || ssym == SymKpDecimal);
    letter_hit = caps_lock_state[0] && nsym >= SymLowerA && nsym <= SymLowerZ;
    take_shifted = (keypad_hit || letter_hit) ^ shift_down;
    res.key_sym      = take_shifted ? ssym : nsym;
    res.is_press     = pressed;
    res.used_shifted = take_shifted;
    res.quit_request = (res.key_sym == SymBackSpace) && control_down && alt_down;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kks_result_t want;
    logic        bad;
    if (!rst_ni) begin
      shift_down      = 1'b0;
      control_down    = 1'b0;
      alt_down        = 1'b0;
      caps_lock_state = 2'b00;
      num_lock_state  = 2'b00;
      expected_keysyms.delete();
      pending_count  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_keysyms.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("%0t: result transfer %h with no event pending", $realtime, m_axis_tdata);
          end
        end else begin
          want = expected_keysyms.pop_front();
          bad  = (m_axis_tdata[15:0] !== want.key_sym) ||
                 (m_axis_tdata[16] !== want.is_press) ||
                 (m_axis_tdata[17] !== want.used_shifted) ||
                 (m_axis_tdata[18] !== want.quit_request) ||
                 (m_axis_tdata[23:19] !== 5'd0);
          if (bad) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: mismatch keysym %h/%h press %b/%b shifted %b/%b quit %b/%b pad %b",
                       $realtime, want.key_sym, m_axis_tdata[15:0], want.is_press,
                       m_axis_tdata[16], want.used_shifted, m_axis_tdata[17],
                       want.quit_request, m_axis_tdata[18], m_axis_tdata[23:19]);
              $display("  (pairs are expected/actual)");
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OpEvent) begin
          expected_keysyms.push_back(translate_key_event(s_axis_tdata[6:0], s_axis_tdata[7]));
        end else if (s_axis_tdata[6:0] < NUM_KEYS) begin
          normal_keysyms[s_axis_tdata[6:0]]  = s_axis_tdata[23:8];
          shifted_keysyms[s_axis_tdata[6:0]] = s_axis_tdata[39:24];
        end
      end
      pending_count  <= expected_keysyms.size();
      mismatch_count <= mismatch_total;
    end
  end

endmodule

// File: verif/keycode_to_keysym_modifiers_tb.sv
// Top of the keycode translator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module keycode_to_keysym_modifiers_tb;
  import kks_pkg::*;

  localparam int unsigned NumKeys     = 128;
  localparam int unsigned RandomItems = 1525;

  localparam logic [SymW-1:0] OddSyms [18] = '{
    SymShiftL, SymShiftR, SymCtrlL, SymCtrlR, SymCapsLock, SymAltL, SymAltR, SymNumLock,
    SymBackSpace, SymKp0, SymKp9, SymKpDecimal, SymKp0 - 16'd1, SymKp9 + 16'd1,
    SymLowerA, SymLowerZ, SymLowerA - 16'd1, SymLowerZ + 16'd1
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = OpLoad;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned sender_idle_pct   = 13;
  int unsigned receiver_idle_pct = 60;

  bit          key_loaded [NumKeys];
  int unsigned loaded_codes [$];

  keycode_to_keysym_modifiers #(.NUM_KEYS(NumKeys)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  keysym_translation_monitor #(.NUM_KEYS(NumKeys)) translation_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Holds valid until the transfer completes; random gaps come before each item.
  task automatic send_item(input logic op, input logic [6:0] code, input logic pressed,
                           input logic [SymW-1:0] nsym, input logic [SymW-1:0] ssym);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {ssym, nsym, pressed, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic load_key(input logic [6:0] code, input logic [SymW-1:0] nsym,
                          input logic [SymW-1:0] ssym);
    send_item(OpLoad, code, 1'($urandom_range(0, 1)), nsym, ssym);
    if (!key_loaded[code]) begin
      key_loaded[code] = 1'b1;
      loaded_codes.push_back(code);
    end
  endtask

  // The keysym fields are ignored on events, so they carry noise.
  task automatic key_event(input logic [6:0] code, input logic pressed);
    send_item(OpEvent, code, pressed, 16'($urandom()), 16'($urandom()));
  endtask

  function automatic logic [SymW-1:0] pick_keysym();
    case ($urandom_range(0, 3))
      0, 1:    return OddSyms[$urandom_range(0, 17)];
      2:       return 16'($urandom_range(SymLowerA, SymLowerZ));
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, every modifier kind, lock latch, quit and stray releases.
    load_key(7'd0,   SymShiftL,    SymShiftL);
    load_key(7'd1,   SymCtrlL,     SymCtrlL);
    load_key(7'd2,   SymAltL,      SymAltL);
    load_key(7'd3,   SymCapsLock,  SymCapsLock);
    load_key(7'd4,   SymNumLock,   SymNumLock);
    load_key(7'd5,   SymLowerA,    16'h0041);
    load_key(7'd6,   16'hFF9C,     SymKp0);
    load_key(7'd7,   SymBackSpace, SymBackSpace);
    load_key(7'd127, 16'hFFFF,     16'h0000);
    load_key(7'd8,   16'h0000,     16'hFFFF);
    key_event(7'd127, 1'b1);
    key_event(7'd8,   1'b0);
    key_event(7'd2,   1'b0);
    key_event(7'd0,   1'b1);
    key_event(7'd5,   1'b1);
    key_event(7'd0,   1'b0);
    key_event(7'd3,   1'b1);
    key_event(7'd3,   1'b1);
    key_event(7'd5,   1'b1);
    key_event(7'd3,   1'b0);
    key_event(7'd1,   1'b1);
    key_event(7'd2,   1'b1);
    key_event(7'd7,   1'b1);
    key_event(7'd4,   1'b1);
    key_event(7'd6,   1'b1);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) begin
        sender_idle_pct   <= 60;
        receiver_idle_pct <= 13;
      end else if (n == 2 * RandomItems / 3) begin
        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
      end
      if ($urandom_range(0, 99) < 12) begin
        load_key(7'($urandom_range(0, NumKeys - 1)), pick_keysym(), pick_keysym());
      end else begin
        key_event(7'(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]),
                  1'($urandom_range(0, 1)));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("keycode_to_keysym_modifiers regression: pass");
    end else begin
      $display("keycode_to_keysym_modifiers regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("keycode_to_keysym_modifiers regression: fail");
    $finish;
  end

endmodule

// File: keycode_to_keysym_modifiers.f
design/kks_pkg.sv
design/kks_table.sv
design/kks_mod.sv
design/keycode_to_keysym_modifiers.sv
verif/keysym_translation_monitor.sv
verif/keycode_to_keysym_modifiers_tb.sv
